// ===== rtl/int64_c_semantics_alu_defines.svh =====
// Assertion macros for the ALU top module.
// Included by files that carry concurrent assertions.
`ifndef INT64_C_SEMANTICS_ALU_DEFINES_SVH
`define INT64_C_SEMANTICS_ALU_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ALU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ialu_pkg.sv =====
// Package for the 64-bit C-semantics ALU: widths, opcodes, cell payload type.
// No dependencies.
package ialu_pkg;
  localparam int W = 64;
  localparam int NCELL = W;  // one divider cell per quotient bit

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_SHL = 5'd7, OP_SHR = 5'd8, OP_XOR = 5'd9,
    OP_EQ = 5'd10, OP_NE = 5'd11, OP_LT = 5'd12, OP_LE = 5'd13, OP_GT = 5'd14,
    OP_GE = 5'd15, OP_LAND = 5'd16, OP_LOR = 5'd17, OP_PLUS = 5'd18,
    OP_NEG = 5'd19, OP_LNOT = 5'd20, OP_BNOT = 5'd21, OP_INC = 5'd22,
    OP_DEC = 5'd23
  } op_t;

  // Payload carried down the cell chain.
  typedef struct packed {
    logic         vld;
    logic [W-1:0] rem;   // partial remainder
    logic [W-1:0] quo;   // dividend bits shift out, quotient bits shift in
    logic [W-1:0] dvs;   // divisor magnitude
    logic [W-1:0] res;   // result of non-divide ops
    logic         bad;
    logic         isdiv;
    logic         ismod;
    logic         negq;
    logic         negr;
    logic         dz;
  } cell_t;
endpackage

// ===== rtl/ialu_if.sv =====
// Valid/ready channel interfaces for the ALU.
// No dependencies.
interface ialu_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic        is_unsigned;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, op, is_unsigned, operand_a, operand_b, input ready);
  modport sink (input valid, op, is_unsigned, operand_a, operand_b, output ready);
endinterface

interface ialu_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        bad_op;
  modport source (output valid, result, bad_op, input ready);
  modport sink (input valid, result, bad_op, output ready);
endinterface

// ===== rtl/ialu_front.sv =====
// Input stage: decodes the op and computes all non-divide results, one register.
// Depends on ialu_pkg. The 64x64 multiply is split into three 32x32 partials.
module ialu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [4:0]     op,
  input  logic           is_unsigned,
  input  logic [63:0]    a,
  input  logic [63:0]    b,
  output ialu_pkg::cell_t q
);
  import ialu_pkg::*;

  logic sgn, nega, negb, lt, eq;
  logic [5:0] sh;
  logic [W-1:0] ma, mb, r, shr;
  logic [W-1:0] p_ll, p_lh, p_hl;
  logic [W-1:0] mul;
  cell_t d;

  always_comb begin
    sgn  = !is_unsigned;
    nega = sgn && a[W-1];
    negb = sgn && b[W-1];
    ma   = nega ? (W'(0) - a) : a;
    mb   = negb ? (W'(0) - b) : b;
    sh   = b[5:0];
    eq   = (a == b);
    lt   = (a ^ {sgn, {(W-1){1'b0}}}) < (b ^ {sgn, {(W-1){1'b0}}});
    shr  = W'($signed({nega, a}) >>> sh);
    p_ll = a[31:0] * b[31:0];
    p_lh = a[31:0] * b[63:32];
    p_hl = a[63:32] * b[31:0];
    mul  = p_ll + {p_lh[31:0] + p_hl[31:0], 32'd0};
    r    = '0;
    case (op)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = mul;
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_SHL:  r = a << sh;
      OP_SHR:  r = shr;
      OP_XOR:  r = a ^ b;
      OP_EQ:   r = W'(eq);
      OP_NE:   r = W'(!eq);
      OP_LT:   r = W'(lt);
      OP_LE:   r = W'(lt || eq);
      OP_GT:   r = W'(!(lt || eq));
      OP_GE:   r = W'(!lt);
      OP_LAND: r = W'((a != '0) && (b != '0));
      OP_LOR:  r = W'((a != '0) || (b != '0));
      OP_PLUS: r = a;
      OP_NEG:  r = sgn ? (W'(0) - a) : a;
      OP_LNOT: r = W'(a == '0);
      OP_BNOT: r = ~a;
      OP_INC:  r = a + W'(1);
      OP_DEC:  r = a - W'(1);
      default: r = '0;
    endcase
    d.vld   = in_vld;
    d.rem   = '0;
    d.quo   = ma;
    d.dvs   = mb;
    d.res   = r;
    d.bad   = (op > 5'd23);
    d.isdiv = (op == OP_DIV);
    d.ismod = (op == OP_MOD);
    d.negq  = nega ^ negb;
    d.negr  = nega;
    d.dz    = (b == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= d;
    end
  end
endmodule

// ===== rtl/ialu_cell.sv =====
// One restoring-division cell: produces one quotient bit and passes on.
// Depends on ialu_pkg.
module ialu_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ialu_pkg::cell_t d,
  output ialu_pkg::cell_t q
);
  import ialu_pkg::*;

  logic [W:0] trial;
  logic [W:0] diff;
  cell_t n;

  always_comb begin
    n     = d;
    trial = {d.rem, d.quo[W-1]};
    diff  = trial - {1'b0, d.dvs};
    if (!diff[W]) begin
      n.rem = diff[W-1:0];
    end else begin
      n.rem = trial[W-1:0];
    end
    n.quo = {d.quo[W-2:0], !diff[W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= n;
    end
  end
endmodule

// ===== rtl/int64_c_semantics_alu.sv =====
// 64-bit integer ALU with C operator semantics.
// Input channel in (op, is_unsigned, operand_a, operand_b) and output channel
// out (result, bad_op), both valid/ready; a transfer happens when both are high.
// Every item goes through the same pipeline: one decode/execute stage that
// computes all non-divide ops (multiply from 32x32 partials), then a row of
// 64 restoring-divide cells that each settle one quotient bit, then an output
// register. Throughput is one item per cycle while the output is not stalled,
// set by the one-bit-per-cell divider row. The whole pipeline advances together:
// when the receiver stalls with a result waiting, every stage holds and in.ready
// drops; bubbles in the pipe stay where they are while a result waits.
// Synchronous active-high rst empties all stages; nothing else is stored.
// Divide or modulo by zero gives 0; ops 24..31 give 0 with bad_op set.
// Depends on ialu_pkg, ialu_if, ialu_front, ialu_cell and the defines header.
`include "int64_c_semantics_alu_defines.svh"
module int64_c_semantics_alu (
  input  logic clk,
  input  logic rst,
  ialu_in_if.sink    in,
  ialu_out_if.source out
);
  import ialu_pkg::*;

  cell_t chain [NCELL+1];
  cell_t fin;
  logic  en;
  logic  ovld;
  logic [W-1:0] ores;
  logic         obad;
  logic [W-1:0] qv, rv;

  assign en       = !ovld || out.ready;
  assign in.ready = en;

  ialu_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_vld(in.valid), .op(in.op),
    .is_unsigned(in.is_unsigned), .a(in.operand_a), .b(in.operand_b),
    .q(chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ialu_cell u_cell (.clk(clk), .rst(rst), .en(en), .d(chain[i]), .q(chain[i+1]));
  end

  always_comb begin
    fin = chain[NCELL];
    qv  = fin.negq ? (W'(0) - fin.quo) : fin.quo;
    rv  = fin.negr ? (W'(0) - fin.rem) : fin.rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (en) begin
      ovld <= fin.vld;
      obad <= fin.bad;
      if (fin.dz && (fin.isdiv || fin.ismod)) begin
        ores <= '0;
      end else if (fin.isdiv) begin
        ores <= qv;
      end else if (fin.ismod) begin
        ores <= rv;
      end else begin
        ores <= fin.res;
      end
    end
  end

  assign out.valid  = ovld;
  assign out.result = ores;
  assign out.bad_op = obad;

  `ALU_ASSERT_IMP(a_ready_rule, out.valid && !out.ready, !in.ready)
  `ALU_ASSERT_NEXT(a_hold, out.valid && !out.ready, out.valid && $stable(out.result))
  `ALU_ASSERT_IMP(a_bad_zero, out.valid && out.bad_op, out.result == '0)
endmodule

// ===== test/int64_c_semantics_alu_test.sv =====
// Testbench for int64_c_semantics_alu: directed table then random operations,
// each result checked in order against a built-in ALU predictor.
// Depends on ialu_pkg, ialu_if and the RTL.
module int64_c_semantics_alu_test;
  import ialu_pkg::*;

  localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int N_RANDOM = 1750;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [4:0]  op;
    logic        uns;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;
    logic [63:0] res;
    logic        bad;
  } row_t;

  typedef struct {
    logic [63:0] res;
    logic        bad;
  } alu_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   cycles = 0;
  bit   stim_done = 1'b0;
  alu_out_t pending[$];
  row_t table_rows[$];

  ialu_in_if  in_ch (clk);
  ialu_out_if out_ch (clk);

  int64_c_semantics_alu dut (.clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source));

  always #1 clk = ~clk;

  function automatic logic [63:0] magnitude(logic [63:0] x, logic sgn);
    return (sgn && x[63]) ? -x : x;
  endfunction

  function automatic alu_out_t alu_eval(logic [4:0] op, logic uns, logic [63:0] a,
                                        logic [63:0] b);
    alu_out_t o;
    logic sgn;
    logic [63:0] ca, cb, q, r;
    logic [5:0] sh;
    sgn = ~uns;
    ca = sgn ? a ^ SIGN : a;
    cb = sgn ? b ^ SIGN : b;
    sh = b[5:0];
    o.bad = 1'b0;
    o.res = '0;
    case (op)
      OP_ADD: o.res = a + b;
      OP_SUB: o.res = a - b;
      OP_MUL: o.res = a * b;
      OP_DIV, OP_MOD: if (b != 0) begin
        q = magnitude(a, sgn) / magnitude(b, sgn);
        r = magnitude(a, sgn) % magnitude(b, sgn);
        if (op == OP_DIV) o.res = (sgn && (a[63] != b[63])) ? -q : q;
        else o.res = (sgn && a[63]) ? -r : r;
      end
      OP_AND: o.res = a & b;
      OP_OR: o.res = a | b;
      OP_SHL: o.res = a << sh;
      OP_SHR: o.res = (sgn && a[63]) ? ~((~a) >> sh) : a >> sh;
      OP_XOR: o.res = a ^ b;
      OP_EQ: o.res = 64'(a == b);
      OP_NE: o.res = 64'(a != b);
      OP_LT: o.res = 64'(ca < cb);
      OP_LE: o.res = 64'(ca <= cb);
      OP_GT: o.res = 64'(ca > cb);
      OP_GE: o.res = 64'(ca >= cb);
      OP_LAND: o.res = 64'((a != 0) && (b != 0));
      OP_LOR: o.res = 64'((a != 0) || (b != 0));
      OP_PLUS: o.res = a;
      OP_NEG: o.res = sgn ? -a : a;
      OP_LNOT: o.res = 64'(a == 0);
      OP_BNOT: o.res = ~a;
      OP_INC: o.res = a + 1;
      OP_DEC: o.res = a - 1;
      default: o.bad = 1'b1;
    endcase
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = ALL1;
      2: v = SIGN;
      3: v = ~SIGN;
      4: v = 64'($urandom_range(0, 70));
      5: v = -64'($urandom_range(1, 70));
      default: ;
    endcase
    return v;
  endfunction

  function automatic row_t mk(logic [4:0] op, logic uns, logic [63:0] a, logic [63:0] b,
                              logic known, logic [63:0] res, logic bad);
    row_t t;
    t.op = op; t.uns = uns; t.a = a; t.b = b; t.known = known; t.res = res; t.bad = bad;
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(logic [4:0] op, logic uns, logic [63:0] a, logic [63:0] b,
                      alu_out_t want);
    int idle;
    idle = $urandom_range(0, 3);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.is_unsigned <= uns;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending.push_back(want);
    @(negedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.is_unsigned = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
  end

  // Directed: extremes, division corner cases, bad opcodes.
  initial begin
    table_rows.push_back(mk(OP_ADD, 1'b0, ALL1, 64'd1, 1'b1, 64'd0, 1'b0));
    table_rows.push_back(mk(OP_ADD, 1'b1, ~SIGN, 64'd1, 1'b1, SIGN, 1'b0));
    table_rows.push_back(mk(OP_SUB, 1'b0, 64'd0, 64'd1, 1'b1, ALL1, 1'b0));
    table_rows.push_back(mk(OP_MUL, 1'b0, ALL1, ALL1, 1'b1, 64'd1, 1'b0));
    table_rows.push_back(mk(OP_DIV, 1'b0, 64'd7, 64'd0, 1'b1, 64'd0, 1'b0));
    table_rows.push_back(mk(OP_MOD, 1'b1, ALL1, 64'd0, 1'b1, 64'd0, 1'b0));
    table_rows.push_back(mk(OP_DIV, 1'b0, SIGN, ALL1, 1'b1, SIGN, 1'b0));
    table_rows.push_back(mk(OP_MOD, 1'b0, SIGN, ALL1, 1'b1, 64'd0, 1'b0));
    table_rows.push_back(mk(OP_DIV, 1'b0, -64'd7, 64'd2, 1'b0, '0, 1'b0));
    table_rows.push_back(mk(OP_MOD, 1'b0, -64'd7, 64'd2, 1'b0, '0, 1'b0));
    table_rows.push_back(mk(OP_DIV, 1'b1, ALL1, 64'd3, 1'b0, '0, 1'b0));
    table_rows.push_back(mk(OP_AND, 1'b0, ALL1, 64'h0F0F, 1'b0, '0, 1'b0));
    table_rows.push_back(mk(OP_OR, 1'b1, SIGN, 64'd1, 1'b0, '0, 1'b0));
    table_rows.push_back(mk(OP_SHL, 1'b0, ALL1, 64'd63, 1'b1, SIGN, 1'b0));
    table_rows.push_back(mk(OP_SHR, 1'b0, SIGN, 64'd63, 1'b1, ALL1, 1'b0));
    table_rows.push_back(mk(OP_SHR, 1'b1, SIGN, 64'hFFC0, 1'b1, SIGN, 1'b0));
    table_rows.push_back(mk(OP_XOR, 1'b0, ALL1, SIGN, 1'b0, '0, 1'b0));
    table_rows.push_back(mk(OP_LT, 1'b0, SIGN, 64'd0, 1'b1, 64'd1, 1'b0));
    table_rows.push_back(mk(OP_LT, 1'b1, SIGN, 64'd0, 1'b1, 64'd0, 1'b0));
    table_rows.push_back(mk(OP_GE, 1'b0, ~SIGN, ALL1, 1'b0, '0, 1'b0));
    table_rows.push_back(mk(OP_NEG, 1'b1, 64'd5, '0, 1'b1, 64'd5, 1'b0));
    table_rows.push_back(mk(OP_NEG, 1'b0, SIGN, '0, 1'b1, SIGN, 1'b0));
    table_rows.push_back(mk(OP_INC, 1'b0, ALL1, '0, 1'b1, 64'd0, 1'b0));
    table_rows.push_back(mk(5'd24, 1'b0, ALL1, ALL1, 1'b1, 64'd0, 1'b1));
    table_rows.push_back(mk(5'd31, 1'b1, ALL1, ALL1, 1'b1, 64'd0, 1'b1));
    for (int i = 0; i < 8; i++)
      table_rows.push_back(mk(5'(10 + i) == 5'd16 ? OP_LAND : 5'(10 + i) , 1'(i),
                              64'(i & 1), 64'(i >> 1), 1'b0, '0, 1'b0));
    table_rows.push_back(mk(OP_PLUS, 1'b0, SIGN, '0, 1'b0, '0, 1'b0));
    table_rows.push_back(mk(OP_LNOT, 1'b0, 64'd0, '0, 1'b1, 64'd1, 1'b0));
    table_rows.push_back(mk(OP_BNOT, 1'b0, ALL1, '0, 1'b1, 64'd0, 1'b0));
    table_rows.push_back(mk(OP_DEC, 1'b1, 64'd0, '0, 1'b1, ALL1, 1'b0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (table_rows[i]) begin
      alu_out_t want;
      want = alu_eval(table_rows[i].op, table_rows[i].uns, table_rows[i].a, table_rows[i].b);
      // known rows: the typed-in value is what the DUT must give
      if (table_rows[i].known) begin
        if (want.res !== table_rows[i].res || want.bad !== table_rows[i].bad)
          report("table row", want.res, table_rows[i].res);
        want.res = table_rows[i].res;
        want.bad = table_rows[i].bad;
      end
      send(table_rows[i].op, table_rows[i].uns, table_rows[i].a, table_rows[i].b, want);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      logic [4:0] op;
      logic u;
      logic [63:0] ra, rb;
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(24, 31))
                                        : 5'($urandom_range(0, 23));
      u = 1'($urandom);
      ra = rand64();
      rb = rand64();
      send(op, u, ra, rb, alu_eval(op, u, ra, rb));
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: at random holds ready low before taking each result.
  initial begin
    @(negedge clk);
    forever begin
      int idle;
      idle = $urandom_range(0, 3);
      if (idle > 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        report("unexpected transfer", out_ch.result, '0);
      end else begin
        alu_out_t w;
        w = pending.pop_front();
        if (out_ch.result !== w.res) report("result", out_ch.result, w.res);
        if (out_ch.bad_op !== w.bad) report("bad_op", 64'(out_ch.bad_op), 64'(w.bad));
      end
    end
  end

  initial begin
    wait (stim_done && pending.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("int64_c_semantics_alu test passed");
    else $display("int64_c_semantics_alu test failed");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("int64_c_semantics_alu test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ialu_pkg.sv
rtl/ialu_if.sv
rtl/ialu_front.sv
rtl/ialu_cell.sv
rtl/int64_c_semantics_alu.sv
test/int64_c_semantics_alu_test.sv
